// File: src/lfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

    // Number format
    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * WORD_W;
    localparam int QUO_W  = WORD_W + FRAC_W;
    localparam int CNT_W  = 6;
    localparam int PC_W   = 6;

    localparam logic signed [WORD_W-1:0] ONE_Q   = WORD_W'(1 << FRAC_W);
    localparam logic signed [WORD_W-1:0] TENTH_Q = WORD_W'(((1 << FRAC_W) + 5) / 10);

    // Commands
    localparam logic [1:0] CMD_UPDATE    = 2'd0;
    localparam logic [1:0] CMD_LOAD      = 2'd1;
    localparam logic [1:0] CMD_LOAD_RST  = 2'd2;

    // Shared unit operations
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;

    // Operand / destination codes; codes below 16 address scratch memory
    localparam logic [4:0] SRC_A    = 5'd16;
    localparam logic [4:0] SRC_B    = 5'd17;
    localparam logic [4:0] SRC_P00  = 5'd18;
    localparam logic [4:0] SRC_P01  = 5'd19;
    localparam logic [4:0] SRC_P10  = 5'd20;
    localparam logic [4:0] SRC_P11  = 5'd21;
    localparam logic [4:0] SRC_T    = 5'd22;
    localparam logic [4:0] SRC_Y    = 5'd23;
    localparam logic [4:0] SRC_R    = 5'd24;
    localparam logic [4:0] SRC_ONE  = 5'd25;
    localparam logic [4:0] SRC_E    = 5'd26;

    localparam logic [PC_W-1:0] LAST_PC = 6'd60;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [WORD_W-1:0] abscissa;
        logic signed [WORD_W-1:0] measurement;
        logic [30:0]              noise_variance;
        logic signed [WORD_W-1:0] load_intercept;
        logic signed [WORD_W-1:0] load_slope;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] intercept;
        logic signed [WORD_W-1:0] slope;
        logic signed [WORD_W-1:0] residual;
        logic                     overflow;
    } t_out_word;

    typedef struct packed {
        logic                     start;
        logic [2:0]               op;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] res;
        logic                     ov;
    } t_alu_rsp;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] sa;
        logic [4:0] sb;
        logic [4:0] dst;
    } t_uop;

    // Microprogram of one update: den, gains, residual, estimates, Joseph form
    function automatic t_uop f_uop(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{OP_ADD, SRC_A, SRC_A, 5'd0};
        case (pc)
            6'd0:  u = '{OP_MUL, SRC_P10, SRC_T,   5'd0};
            6'd1:  u = '{OP_ADD, SRC_P00, 5'd0,    5'd1};
            6'd2:  u = '{OP_MUL, SRC_P01, SRC_T,   5'd0};
            6'd3:  u = '{OP_ADD, 5'd1,    5'd0,    5'd1};
            6'd4:  u = '{OP_MUL, SRC_P11, SRC_T,   5'd0};
            6'd5:  u = '{OP_MUL, 5'd0,    SRC_T,   5'd0};
            6'd6:  u = '{OP_ADD, 5'd1,    5'd0,    5'd1};
            6'd7:  u = '{OP_ADD, 5'd1,    SRC_R,   5'd1};
            6'd8:  u = '{OP_MUL, SRC_P01, SRC_T,   5'd0};
            6'd9:  u = '{OP_ADD, SRC_P00, 5'd0,    5'd2};
            6'd10: u = '{OP_MUL, SRC_P11, SRC_T,   5'd0};
            6'd11: u = '{OP_ADD, SRC_P10, 5'd0,    5'd3};
            6'd12: u = '{OP_DIV, 5'd2,    5'd1,    5'd4};
            6'd13: u = '{OP_DIV, 5'd3,    5'd1,    5'd5};
            6'd14: u = '{OP_SUB, SRC_Y,   SRC_A,   5'd0};
            6'd15: u = '{OP_MUL, SRC_B,   SRC_T,   5'd2};
            6'd16: u = '{OP_SUB, 5'd0,    5'd2,    SRC_E};
            6'd17: u = '{OP_MUL, 5'd4,    SRC_E,   5'd0};
            6'd18: u = '{OP_ADD, SRC_A,   5'd0,    SRC_A};
            6'd19: u = '{OP_MUL, 5'd5,    SRC_E,   5'd0};
            6'd20: u = '{OP_ADD, SRC_B,   5'd0,    SRC_B};
            6'd21: u = '{OP_SUB, SRC_ONE, 5'd4,    5'd6};
            6'd22: u = '{OP_MUL, 5'd4,    SRC_T,   5'd0};
            6'd23: u = '{OP_NEG, 5'd0,    5'd0,    5'd7};
            6'd24: u = '{OP_NEG, 5'd5,    5'd5,    5'd8};
            6'd25: u = '{OP_MUL, 5'd5,    SRC_T,   5'd0};
            6'd26: u = '{OP_SUB, SRC_ONE, 5'd0,    5'd9};
            6'd27: u = '{OP_MUL, 5'd6,    SRC_P00, 5'd0};
            6'd28: u = '{OP_MUL, 5'd7,    SRC_P10, 5'd2};
            6'd29: u = '{OP_ADD, 5'd0,    5'd2,    5'd10};
            6'd30: u = '{OP_MUL, 5'd6,    SRC_P01, 5'd0};
            6'd31: u = '{OP_MUL, 5'd7,    SRC_P11, 5'd2};
            6'd32: u = '{OP_ADD, 5'd0,    5'd2,    5'd11};
            6'd33: u = '{OP_MUL, 5'd8,    SRC_P00, 5'd0};
            6'd34: u = '{OP_MUL, 5'd9,    SRC_P10, 5'd2};
            6'd35: u = '{OP_ADD, 5'd0,    5'd2,    5'd12};
            6'd36: u = '{OP_MUL, 5'd8,    SRC_P01, 5'd0};
            6'd37: u = '{OP_MUL, 5'd9,    SRC_P11, 5'd2};
            6'd38: u = '{OP_ADD, 5'd0,    5'd2,    5'd13};
            6'd39: u = '{OP_MUL, 5'd10,   5'd6,    5'd0};
            6'd40: u = '{OP_MUL, 5'd11,   5'd7,    5'd2};
            6'd41: u = '{OP_ADD, 5'd0,    5'd2,    5'd14};
            6'd42: u = '{OP_MUL, 5'd10,   5'd8,    5'd0};
            6'd43: u = '{OP_MUL, 5'd11,   5'd9,    5'd2};
            6'd44: u = '{OP_ADD, 5'd0,    5'd2,    5'd15};
            6'd45: u = '{OP_MUL, 5'd12,   5'd6,    5'd0};
            6'd46: u = '{OP_MUL, 5'd13,   5'd7,    5'd2};
            6'd47: u = '{OP_ADD, 5'd0,    5'd2,    5'd3};
            6'd48: u = '{OP_MUL, 5'd12,   5'd8,    5'd0};
            6'd49: u = '{OP_MUL, 5'd13,   5'd9,    5'd2};
            6'd50: u = '{OP_ADD, 5'd0,    5'd2,    5'd1};
            6'd51: u = '{OP_MUL, 5'd4,    5'd4,    5'd0};
            6'd52: u = '{OP_MUL, 5'd0,    SRC_R,   5'd6};
            6'd53: u = '{OP_MUL, 5'd5,    5'd4,    5'd0};
            6'd54: u = '{OP_MUL, 5'd0,    SRC_R,   5'd7};
            6'd55: u = '{OP_MUL, 5'd5,    5'd5,    5'd0};
            6'd56: u = '{OP_MUL, 5'd0,    SRC_R,   5'd8};
            6'd57: u = '{OP_ADD, 5'd14,   5'd6,    SRC_P00};
            6'd58: u = '{OP_ADD, 5'd15,   5'd7,    SRC_P01};
            6'd59: u = '{OP_ADD, 5'd3,    5'd7,    SRC_P10};
            6'd60: u = '{OP_ADD, 5'd1,    5'd8,    SRC_P11};
            default: u = '{OP_ADD, SRC_A, SRC_A, 5'd0};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: src/lfr_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input word channel
interface lfr_in_if;
    logic              valid;
    logic              ready;
    lfr_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result word channel
interface lfr_out_if;
    logic               valid;
    logic               ready;
    lfr_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/lfr_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared saturating unit: add, sub and negate registered directly from the
// request, multiply through the A_MULS state, restoring divide bit-serially.
module lfr_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lfr_pkg::t_alu_req i_req,
    output lfr_pkg::t_alu_rsp      o_rsp
);
    import lfr_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MULS = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;

    // {overflow, value} of a 33-bit sum clipped to the word
    function automatic logic [WORD_W:0] f_sat(input logic [WORD_W:0] v);
        logic [WORD_W:0] r;
        r = {1'b0, v[WORD_W-1:0]};
        if (v[WORD_W] != v[WORD_W-1]) begin
            r = {1'b1, v[WORD_W], {(WORD_W-1){~v[WORD_W]}}};
        end
        return r;
    endfunction

    // {overflow, value} of a signed magnitude clipped to the word
    function automatic logic [WORD_W:0] f_from_mag(input logic [QUO_W-1:0] m,
                                                   input logic neg);
        logic [WORD_W:0]  r;
        logic [QUO_W-1:0] lim;
        lim = neg ? (QUO_W'(1) << (WORD_W-1)) : ((QUO_W'(1) << (WORD_W-1)) - QUO_W'(1));
        if (m > lim) begin
            r = {1'b1, neg, {(WORD_W-1){~neg}}};
        end else if (neg) begin
            r = {1'b0, WORD_W'(0) - m[WORD_W-1:0]};
        end else begin
            r = {1'b0, m[WORD_W-1:0]};
        end
        return r;
    endfunction

    logic [1:0]          r_st;
    logic                r_done;
    logic [WORD_W-1:0]   r_res;
    logic                r_ov;
    logic [PROD_W-1:0]   r_prod;
    logic                r_neg;
    logic [QUO_W-1:0]    r_num;
    logic [WORD_W-1:0]   r_den;
    logic [WORD_W:0]     r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;

    logic [WORD_W-1:0]   w_mag_a, w_mag_b;
    logic [WORD_W:0]     w_sum, w_dif, w_neg;
    logic [WORD_W:0]     w_rem_sh, w_rem_nx;
    logic                w_ge;
    logic [QUO_W-1:0]    w_quo_nx;

    // Operand magnitudes and single-cycle results
    always_comb begin
        w_mag_a = i_req.a[WORD_W-1] ? (WORD_W'(0) - i_req.a) : i_req.a;
        w_mag_b = i_req.b[WORD_W-1] ? (WORD_W'(0) - i_req.b) : i_req.b;
        w_sum   = f_sat({i_req.a[WORD_W-1], i_req.a} + {i_req.b[WORD_W-1], i_req.b});
        w_dif   = f_sat({i_req.a[WORD_W-1], i_req.a} - {i_req.b[WORD_W-1], i_req.b});
        w_neg   = f_sat((WORD_W+1)'(0) - {i_req.a[WORD_W-1], i_req.a});
    end

    // Restoring divide step
    always_comb begin
        w_rem_sh = {r_rem[WORD_W-1:0], r_num[QUO_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
        w_quo_nx = {r_quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= A_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_neg <= i_req.a[WORD_W-1] ^ i_req.b[WORD_W-1];
                        case (i_req.op)
                            OP_ADD: begin
                                {r_ov, r_res} <= w_sum;
                                r_done        <= 1'b1;
                            end
                            OP_SUB: begin
                                {r_ov, r_res} <= w_dif;
                                r_done        <= 1'b1;
                            end
                            OP_NEG: begin
                                {r_ov, r_res} <= w_neg;
                                r_done        <= 1'b1;
                            end
                            OP_MUL: begin
                                r_prod <= {{WORD_W{1'b0}}, w_mag_a} * {{WORD_W{1'b0}}, w_mag_b};
                                r_st   <= A_MULS;
                            end
                            OP_DIV: begin
                                if (i_req.b == '0) begin
                                    // zero denominator: gain is zero, flag it
                                    r_res  <= '0;
                                    r_ov   <= 1'b1;
                                    r_done <= 1'b1;
                                end else begin
                                    r_num <= {w_mag_a, {FRAC_W{1'b0}}};
                                    r_den <= w_mag_b;
                                    r_rem <= '0;
                                    r_quo <= '0;
                                    r_cnt <= CNT_W'(QUO_W - 1);
                                    r_st  <= A_DIV;
                                end
                            end
                            default: begin
                                r_res  <= '0;
                                r_ov   <= 1'b0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MULS: begin
                    {r_ov, r_res} <= f_from_mag(r_prod[PROD_W-1:FRAC_W], r_neg);
                    r_done        <= 1'b1;
                    r_st          <= A_IDLE;
                end
                A_DIV: begin
                    r_rem <= w_rem_nx;
                    r_quo <= w_quo_nx;
                    r_num <= {r_num[QUO_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        {r_ov, r_res} <= f_from_mag(w_quo_nx, r_neg);
                        r_done        <= 1'b1;
                        r_st          <= A_IDLE;
                    end
                end
                default: r_st <= A_IDLE;
            endcase
        end
    end

    assign o_rsp = '{r_done, r_res, r_ov};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_st == A_IDLE)
        else $error("unit started while busy");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == A_DIV && r_cnt != '0) |=> (r_st == A_DIV && !r_done))
        else $error("divide ended early");
    a_mul_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == A_MULS) |=> (r_done && r_st == A_IDLE))
        else $error("multiply did not finish in two cycles");

endmodule

`default_nettype wire

// File: src/linear_fit_rls_estimator.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-parameter recursive least-squares line fit, y = a + b*t, Q16.16.
// Input channel i_upd carries one word per command: update (t, y, R),
// load estimates, or load estimates and reset the covariance. The output
// channel o_res returns one word per input word: intercept, slope,
// residual (zero for loads) and an overflow flag for any saturation or a
// zero denominator.
// An update runs a 61-step microprogram through one shared unit; each step
// reads its operands (S_RD), issues (S_EX) and waits for the unit (S_WAIT),
// and each of the two divides produces one quotient bit per cycle. A load
// goes straight to S_DONE. The block accepts one word at a time and is not
// ready while a word is in progress.
// Results sit in an output register; if the receiver stalls, a finished
// word waits there and the next word may already be accepted and worked,
// holding its own result until the register frees.
// Synchronous reset clears the estimates to zero, sets the covariance to
// 1.0, 0.1, 0.1, 0.1 and empties the output register.
module linear_fit_rls_estimator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lfr_in_if.sink     i_upd,
    lfr_out_if.source  o_res
);
    import lfr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]               r_state;
    logic [PC_W-1:0]          r_pc;
    logic signed [WORD_W-1:0] r_a, r_b, r_p00, r_p01, r_p10, r_p11;
    logic signed [WORD_W-1:0] r_t, r_y, r_r, r_e;
    logic                     r_ov;
    logic [WORD_W-1:0]        r_rda, r_rdb;
    logic [WORD_W-1:0]        r_mem [16];
    logic                     r_out_valid;
    t_out_word                r_out;

    t_uop                     w_uop;
    logic signed [WORD_W-1:0] w_opa, w_opb;
    t_alu_req                 w_req;
    t_alu_rsp                 w_rsp;
    logic                     w_acc;
    logic                     w_out_free;

    assign w_uop      = f_uop(r_pc);
    assign w_acc      = i_upd.valid && i_upd.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    // Operand select: scratch memory or named register
    always_comb begin
        case (w_uop.sa)
            SRC_A:   w_opa = r_a;
            SRC_B:   w_opa = r_b;
            SRC_P00: w_opa = r_p00;
            SRC_P01: w_opa = r_p01;
            SRC_P10: w_opa = r_p10;
            SRC_P11: w_opa = r_p11;
            SRC_T:   w_opa = r_t;
            SRC_Y:   w_opa = r_y;
            SRC_R:   w_opa = r_r;
            SRC_ONE: w_opa = ONE_Q;
            SRC_E:   w_opa = r_e;
            default: w_opa = r_rda;
        endcase
        case (w_uop.sb)
            SRC_A:   w_opb = r_a;
            SRC_B:   w_opb = r_b;
            SRC_P00: w_opb = r_p00;
            SRC_P01: w_opb = r_p01;
            SRC_P10: w_opb = r_p10;
            SRC_P11: w_opb = r_p11;
            SRC_T:   w_opb = r_t;
            SRC_Y:   w_opb = r_y;
            SRC_R:   w_opb = r_r;
            SRC_ONE: w_opb = ONE_Q;
            SRC_E:   w_opb = r_e;
            default: w_opb = r_rdb;
        endcase
    end

    assign w_req = '{(r_state == S_EX), w_uop.op, w_opa, w_opb};

    lfr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Scratch memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_rsp.done && !w_uop.dst[4]) begin
            r_mem[w_uop.dst[3:0]] <= w_rsp.res;
        end
        r_rda <= r_mem[w_uop.sa[3:0]];
        r_rdb <= r_mem[w_uop.sb[3:0]];
    end

    // Sequencer and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_p00       <= ONE_Q;
            r_p01       <= TENTH_Q;
            r_p10       <= TENTH_Q;
            r_p11       <= TENTH_Q;
            r_e         <= '0;
            r_ov        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_e  <= '0;
                        r_ov <= 1'b0;
                        r_pc <= '0;
                        r_t  <= i_upd.data.abscissa;
                        r_y  <= i_upd.data.measurement;
                        r_r  <= {1'b0, i_upd.data.noise_variance};
                        r_state <= S_DONE;
                        case (i_upd.data.cmd)
                            CMD_UPDATE: r_state <= S_RD;
                            CMD_LOAD: begin
                                r_a <= i_upd.data.load_intercept;
                                r_b <= i_upd.data.load_slope;
                            end
                            CMD_LOAD_RST: begin
                                r_a   <= i_upd.data.load_intercept;
                                r_b   <= i_upd.data.load_slope;
                                r_p00 <= ONE_Q;
                                r_p01 <= TENTH_Q;
                                r_p10 <= TENTH_Q;
                                r_p11 <= TENTH_Q;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_EX;
                S_EX: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_ov <= r_ov | w_rsp.ov;
                        case (w_uop.dst)
                            SRC_A:   r_a   <= w_rsp.res;
                            SRC_B:   r_b   <= w_rsp.res;
                            SRC_P00: r_p00 <= w_rsp.res;
                            SRC_P01: r_p01 <= w_rsp.res;
                            SRC_P10: r_p10 <= w_rsp.res;
                            SRC_P11: r_p11 <= w_rsp.res;
                            SRC_E:   r_e   <= w_rsp.res;
                            default: ;
                        endcase
                        if (r_pc == LAST_PC) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pc    <= r_pc + PC_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out       <= '{r_a, r_b, r_e, r_ov};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_upd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_rsp_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_WAIT)
        else $error("unit result outside wait step");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= LAST_PC)
        else $error("microprogram counter out of range");
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_res.ready) |=> r_state == S_DONE)
        else $error("result overwrote a stalled word");
    a_load_resid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_upd.data.cmd != CMD_UPDATE) |=> (r_e == '0 && r_state == S_DONE))
        else $error("load word left a residual");

endmodule

`default_nettype wire
